// ===== src/pcb_pkg.sv =====
// Package: shared types, mux codes and constants for the pixel color blender.
package pcb_pkg;

   localparam int unsigned ChanW = 8;
   localparam int unsigned ColorW = 32;
   localparam int unsigned NumW = 17;
   localparam int unsigned DenW = 9;
   localparam int unsigned QuotW = 9;
   localparam int unsigned DivBitsPerStage = 3;
   localparam int unsigned DivStages = (QuotW + DivBitsPerStage - 1) / DivBitsPerStage;
   localparam logic [ChanW-1:0] FullScale = 8'd255;

   typedef enum logic [1:0] {
      CSEL_COMBINED = 2'd0,
      CSEL_MEMORY   = 2'd1,
      CSEL_BLEND    = 2'd2,
      CSEL_FOG      = 2'd3
   } color_sel_type;

   typedef enum logic [1:0] {
      ASEL_COMBINED = 2'd0,
      ASEL_FOG      = 2'd1,
      ASEL_SHADE    = 2'd2,
      ASEL_ZERO     = 2'd3
   } alpha_sel_type;

   typedef enum logic [1:0] {
      BSEL_INV_A  = 2'd0,
      BSEL_MEMORY = 2'd1,
      BSEL_FULL   = 2'd2,
      BSEL_ZERO   = 2'd3
   } beta_sel_type;

   typedef enum logic [1:0] {
      CSR_SELECT_PASS0 = 2'd0,
      CSR_SELECT_PASS1 = 2'd1,
      CSR_BLEND_COLOR  = 2'd2,
      CSR_FOG_COLOR    = 2'd3
   } csr_index_type;

   // one lane of the divider pipeline
   typedef struct packed {
      logic [NumW-1:0]  rem;
      logic [QuotW-1:0] quot;
   } div_lane_type;

   function automatic logic [ChanW-1:0] chan_of(input logic [ColorW-1:0] c,
                                                input logic [1:0] k);
      logic [ColorW-1:0] s;
      s = c >> (ColorW - ChanW - ChanW * 32'(k));
      return s[ChanW-1:0];
   endfunction

endpackage

// ===== src/pcb_weight.sv =====
// Weight stage: mux selection and per-channel products A*P + B*M, registered.
module pcb_weight
   import pcb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    pass_index,
   input  logic [ColorW-1:0]       combined_color,
   input  logic [ColorW-1:0]       memory_color,
   input  logic [ChanW-1:0]        shade_alpha,
   input  logic [ChanW-1:0]        select_pass0,
   input  logic [ChanW-1:0]        select_pass1,
   input  logic [ColorW-1:0]       blend_color,
   input  logic [ColorW-1:0]       fog_color,
   output logic                    out_valid,
   output logic [3:0][NumW-1:0]    out_num,
   output logic [DenW-1:0]         out_den
);

   logic [ChanW-1:0]     sel;
   logic [ColorW-1:0]    p_color;
   logic [ColorW-1:0]    m_color;
   logic [ChanW-1:0]     a_w;
   logic [ChanW-1:0]     b_w;
   logic                 valid_ff;
   logic [3:0][NumW-1:0] num_ff, num_in;
   logic [DenW-1:0]      den_ff, den_in;

   function automatic logic [ColorW-1:0] pick(input logic [1:0] code,
                                              input logic [ColorW-1:0] comb,
                                              input logic [ColorW-1:0] mem,
                                              input logic [ColorW-1:0] blend,
                                              input logic [ColorW-1:0] fog);
      logic [ColorW-1:0] r;
      case (color_sel_type'(code))
         CSEL_COMBINED: r = comb;
         CSEL_MEMORY:   r = mem;
         CSEL_BLEND:    r = blend;
         CSEL_FOG:      r = fog;
         default:       r = fog;
      endcase
      return r;
   endfunction

   always_comb begin
      sel = pass_index ? select_pass1 : select_pass0;
      p_color = pick(sel[1:0], combined_color, memory_color, blend_color, fog_color);
      m_color = pick(sel[5:4], combined_color, memory_color, blend_color, fog_color);
      case (alpha_sel_type'(sel[3:2]))
         ASEL_COMBINED: a_w = combined_color[ChanW-1:0];
         ASEL_FOG:      a_w = fog_color[ChanW-1:0];
         ASEL_SHADE:    a_w = shade_alpha;
         ASEL_ZERO:     a_w = '0;
         default:       a_w = '0;
      endcase
      case (beta_sel_type'(sel[7:6]))
         BSEL_INV_A:  b_w = FullScale - a_w;
         BSEL_MEMORY: b_w = memory_color[ChanW-1:0];
         BSEL_FULL:   b_w = FullScale;
         BSEL_ZERO:   b_w = '0;
         default:     b_w = '0;
      endcase
      den_in = {1'b0, a_w} + {1'b0, b_w};
      for (int k = 0; k < 4; k++) begin
         num_in[k] = NumW'(a_w) * NumW'(chan_of(p_color, 2'(k)))
                   + NumW'(b_w) * NumW'(chan_of(m_color, 2'(k)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

// ===== src/pcb_divide.sv =====
// Divider: pipelined restoring division of four numerators by a shared denominator.
module pcb_divide
   import pcb_pkg::*;
#(
   parameter int unsigned BitsPerStage = DivBitsPerStage
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [3:0][NumW-1:0]    in_num,
   input  logic [DenW-1:0]         in_den,
   output logic                    out_valid,
   output logic [3:0][ChanW-1:0]   out_quot
);

   localparam int unsigned Stages = (QuotW + BitsPerStage - 1) / BitsPerStage;

   logic [Stages:1]                  valid_ff;
   logic [Stages:1][DenW-1:0]        den_ff;
   logic [Stages:1][3:0][NumW-1:0]   rem_ff;
   logic [Stages:1][3:0][QuotW-1:0]  quot_ff;
   logic                             oval_ff;
   logic [3:0][ChanW-1:0]            oq_ff, oq_in;

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic                  valid_cur;
      logic [DenW-1:0]       den_cur;
      logic [3:0][NumW-1:0]  rem_cur;
      logic [3:0][QuotW-1:0] quot_cur;
      logic [3:0][NumW-1:0]  rem_in;
      logic [3:0][QuotW-1:0] quot_in;

      // first stage takes the input without a register
      if (s == 0) begin : g_first
         assign valid_cur = in_valid;
         assign den_cur   = in_den;
         assign rem_cur   = in_num;
         assign quot_cur  = '0;
      end else begin : g_next
         assign valid_cur = valid_ff[s];
         assign den_cur   = den_ff[s];
         assign rem_cur   = rem_ff[s];
         assign quot_cur  = quot_ff[s];
      end

      always_comb begin
         logic [NumW+QuotW-1:0] trial;
         logic [NumW+QuotW-1:0] dsh;
         int                    bitpos;
         rem_in  = rem_cur;
         quot_in = quot_cur;
         for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < BitsPerStage; j++) begin
               bitpos = QuotW - 1 - s * BitsPerStage - j;
               if (bitpos >= 0) begin
                  dsh   = (NumW+QuotW)'(den_cur) << bitpos;
                  trial = (NumW+QuotW)'(rem_in[k]);
                  if (trial >= dsh) begin
                     trial = trial - dsh;
                     quot_in[k][bitpos] = 1'b1;
                  end
                  rem_in[k] = trial[NumW-1:0];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_cur;
         end
         den_ff[s+1]  <= den_cur;
         rem_ff[s+1]  <= rem_in;
         quot_ff[s+1] <= quot_in;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         oq_in[k] = (den_ff[Stages] == '0) ? '0 : quot_ff[Stages][k][ChanW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oval_ff <= 1'b0;
      end else begin
         oval_ff <= valid_ff[Stages];
      end
      oq_ff <= oq_in;
   end

   assign out_valid = oval_ff;
   assign out_quot  = oq_ff;

endmodule

// ===== src/pixel_color_blender_top.sv =====
// Top level: pixel color blender with registers, weight stage and divider.
//
// Requests enter on req_* : a request is taken at a clock edge with start high
// and busy low. busy is always low, so one pixel can enter every cycle.
// Each pixel picks mux settings by pass index, forms weights A and B and
// colors P and M, and produces (A*P + B*M)/(A+B) per channel; 0 when A+B is 0.
// Results leave on rsp_* with rsp_valid high for exactly one cycle.
// From accept to rsp_valid a pixel passes one weight stage, three
// divider stages of three quotient bits each, and one output register.
// Throughput: one pixel per clock, set by the fully pipelined divider.
// Registers are written on csr_* at any edge with csr_write high, index as
// listed: select_pass0, select_pass1, blend_color, fog_color.
// Synchronous reset clears all valid bits and the registers to 0; requests
// in flight are dropped. The receiver cannot stall; results are never held.
module pixel_color_blender_top
   import pcb_pkg::*;
#(
   parameter int unsigned BitsPerStage = DivBitsPerStage
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_pass_index,
   input  logic [ColorW-1:0] req_combined_color,
   input  logic [ColorW-1:0] req_memory_color,
   input  logic [ChanW-1:0]  req_shade_alpha,
   output logic              rsp_valid,
   output logic [ChanW-1:0]  rsp_out_red,
   output logic [ChanW-1:0]  rsp_out_green,
   output logic [ChanW-1:0]  rsp_out_blue,
   output logic [ChanW-1:0]  rsp_out_alpha,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [ColorW-1:0] csr_data
);

   logic [ChanW-1:0]      sel0_ff, sel1_ff;
   logic [ColorW-1:0]     blend_ff, fog_ff;
   logic                  w_valid;
   logic [3:0][NumW-1:0]  w_num;
   logic [DenW-1:0]       w_den;
   logic [3:0][ChanW-1:0] quot;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel0_ff  <= '0;
         sel1_ff  <= '0;
         blend_ff <= '0;
         fog_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SELECT_PASS0: sel0_ff  <= csr_data[ChanW-1:0];
            CSR_SELECT_PASS1: sel1_ff  <= csr_data[ChanW-1:0];
            CSR_BLEND_COLOR:  blend_ff <= csr_data;
            CSR_FOG_COLOR:    fog_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   pcb_weight u_weight (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (start & ~busy),
      .pass_index     (req_pass_index),
      .combined_color (req_combined_color),
      .memory_color   (req_memory_color),
      .shade_alpha    (req_shade_alpha),
      .select_pass0   (sel0_ff),
      .select_pass1   (sel1_ff),
      .blend_color    (blend_ff),
      .fog_color      (fog_ff),
      .out_valid      (w_valid),
      .out_num        (w_num),
      .out_den        (w_den)
   );

   pcb_divide #(.BitsPerStage(BitsPerStage)) u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (w_valid),
      .in_num    (w_num),
      .in_den    (w_den),
      .out_valid (rsp_valid),
      .out_quot  (quot)
   );

   assign rsp_out_red   = quot[0];
   assign rsp_out_green = quot[1];
   assign rsp_out_blue  = quot[2];
   assign rsp_out_alpha = quot[3];

endmodule

// ===== src/pcb_checker.sv =====
// Checker: port-level properties of the pixel color blender, bound to the top.
module pcb_checker
   import pcb_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   localparam int unsigned Latency = DivStages + 2;

   a_never_busy: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy asserted");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_valid)
      else $error("missing response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("spurious response");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind pixel_color_blender_top pcb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
